>>> src/epr_pkg.sv
package epr_pkg;

  // field widths
  localparam int PixelXW   = 8;
  localparam int PixelYW   = 7;
  localparam int ColorW    = 16;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 7;

  // shared multiplier
  localparam int MulOpW    = 11;
  localparam int MulProdW  = 2 * MulOpW;

  // geometry
  localparam int EyeCy     = 40;
  localparam int EyeCxLeft = 40;
  localparam int EyeCxRight = 120;
  localparam int EyeRxSq   = 1156;
  localparam int IrisRSq   = 324;

  localparam logic [24:0] EllLimOpen  = 25'(EyeRxSq * 1024);
  localparam logic [24:0] EllLimBlink = 25'(EyeRxSq * 9);
  localparam logic [13:0] EdgeLim     = 14'((EyeRxSq * 3) / 4);

  // ring bounds: frac > T  <=>  id_sq >= ceil((T + 1) * 324 / 256)
  localparam logic [13:0] RingOuter = 14'(((200 + 1) * IrisRSq + 255) / 256);
  localparam logic [13:0] RingMid   = 14'(((120 + 1) * IrisRSq + 255) / 256);
  localparam logic [13:0] RingInner = 14'(((50 + 1) * IrisRSq + 255) / 256);

  localparam logic [ColorW-1:0] ColBlack = 16'h0000;
  localparam logic [ColorW-1:0] ColWhite = 16'hFFFF;
  localparam logic [ColorW-1:0] ColWarm  = 16'hF73B;
  localparam logic [ColorW-1:0] ColFaint = 16'hCEFF;

  localparam logic [31:0] NoiseSeed = 32'd123456789;

  typedef enum logic [1:0] {
    MOOD_OPEN  = 2'd0,
    MOOD_ANGRY = 2'd1,
    MOOD_FLAT  = 2'd2,
    MOOD_SAD   = 2'd3
  } mood_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LID_SHAPE    = 3'd0,
    REG_BLINK        = 3'd1,
    REG_OFFSET_X     = 3'd2,
    REG_OFFSET_Y     = 3'd3,
    REG_HUE_PHASE    = 3'd4,
    REG_PUPIL_RADIUS = 3'd5
  } cfg_reg_t;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_SQ_DX  = 9'b000000010,
    S_SQ_DY  = 9'b000000100,
    S_SQ_IX  = 9'b000001000,
    S_SQ_IY  = 9'b000010000,
    S_SHADE  = 9'b000100000,
    S_MUL_G  = 9'b001000000,
    S_MUL_B  = 9'b010000000,
    S_FINISH = 9'b100000000
  } state_t;

  typedef struct packed {
    logic       iris;
    logic       pupil;
    logic       glint_hi;
    logic       glint_lo;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } shade_t;

endpackage

>>> src/epr_if.sv
interface epr_pixel_if;
  logic                          valid;
  logic                          ready;
  logic [epr_pkg::PixelXW-1:0]   pixel_x;
  logic [epr_pkg::PixelYW-1:0]   pixel_y;

  modport source (output valid, pixel_x, pixel_y, input ready);
  modport sink   (input valid, pixel_x, pixel_y, output ready);
endinterface

interface epr_color_if;
  logic                          valid;
  logic                          ready;
  logic [epr_pkg::ColorW-1:0]    pixel_color;

  modport source (output valid, pixel_color, input ready);
  modport sink   (input valid, pixel_color, output ready);
endinterface

>>> src/epr_mul.sv
module epr_mul (
  input  logic                                clk,
  input  logic signed [epr_pkg::MulOpW-1:0]   a,
  input  logic signed [epr_pkg::MulOpW-1:0]   b,
  output logic signed [epr_pkg::MulProdW-1:0] p
);
  import epr_pkg::*;

  // registered product
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

>>> src/epr_shade.sv
module epr_shade (
  input  logic               eye_sel,
  input  logic signed [7:0]  ix,
  input  logic signed [7:0]  iy,
  input  logic [13:0]        id_sq,
  input  logic [31:0]        noise,
  input  logic [3:0]         pupil_radius,
  output epr_pkg::shade_t    sh
);
  import epr_pkg::*;

  // true when hx^2 + hy^2 <= lim, for lim below 16
  function automatic logic near_sq(input logic signed [8:0] hx,
                                   input logic signed [8:0] hy,
                                   input logic [4:0] lim);
    logic [8:0] ax;
    logic [8:0] ay;
    logic [3:0] sx;
    logic [3:0] sy;
    ax = hx[8] ? 9'(-hx) : 9'(hx);
    ay = hy[8] ? 9'(-hy) : 9'(hy);
    if (ax > 9'd3 || ay > 9'd3) begin
      return 1'b0;
    end
    sx = {2'b00, ax[1:0]} * {2'b00, ax[1:0]};
    sy = {2'b00, ay[1:0]} * {2'b00, ay[1:0]};
    return ({1'b0, sx} + {1'b0, sy}) <= lim;
  endfunction

  logic signed [8:0] ix9, iy9;
  logic signed [8:0] hx_hi, hy_hi, hx_lo, hy_lo;
  logic [7:0]        rad_sq;

  assign ix9    = {ix[7], ix};
  assign iy9    = {iy[7], iy};
  assign hx_hi  = eye_sel ? ix9 + 9'sd6 : ix9 - 9'sd6;
  assign hy_hi  = iy9 + 9'sd6;
  assign hx_lo  = eye_sel ? ix9 + 9'sd3 : ix9 - 9'sd3;
  assign hy_lo  = iy9 + 9'sd4;
  assign rad_sq = 8'(pupil_radius) * 8'(pupil_radius);

  always_comb begin
    sh          = '0;
    sh.iris     = id_sq <= 14'(IrisRSq);
    sh.pupil    = id_sq <= {6'b0, rad_sq};
    sh.glint_hi = near_sq(hx_hi, hy_hi, 5'd9);
    sh.glint_lo = near_sq(hx_lo, hy_lo, 5'd4);

    priority if (id_sq >= RingOuter) begin
      sh.r = 8'd10;  sh.g = 8'd50;  sh.b = 8'd60;
    end else if (id_sq >= RingMid) begin
      sh.r = 8'd20;  sh.g = 8'd120; sh.b = 8'd110;
    end else if (id_sq >= RingInner) begin
      sh.r = 8'd40;  sh.g = 8'd180; sh.b = 8'd160;
    end else begin
      sh.r = 8'd80;  sh.g = 8'd220; sh.b = 8'd200;
    end

    // speckle: bright fleck, then dark fleck
    if (noise[3:0] == 4'h0) begin
      sh.r = 8'd200; sh.g = 8'd160; sh.b = 8'd40;
    end
    if (noise[4:0] == 5'h01) begin
      sh.r = 8'd5;   sh.g = 8'd40;  sh.b = 8'd35;
    end
  end

endmodule

>>> src/procedural_eye_pixel_renderer_unit.sv
// Shades one pixel of a 160x80 two-eye panel per beat and returns it as RGB565.
// A pixel beat is taken only while the sequencer is idle; it then walks eight
// steps, and the last step waits while the result register is still full. The
// steps come from the single registered 11x11 multiplier, used six times per
// pixel: dx^2, dy^2, the two iris-distance squares and the green and blue hue
// gains. Finished results sit in an output register, so the next pixel beat is
// taken while a colour still waits. The speckle generator is a xorshift32 word
// seeded by reset; it steps once for each pixel inside the eye that falls in an
// iris. Configuration writes land at once and are meant for idle periods;
// there is no read-back and no clearing pass.
module procedural_eye_pixel_renderer_unit (
  input  logic                          clk,
  input  logic                          rst,
  epr_pixel_if.sink                     pixel_in,
  epr_color_if.source                   color_out,
  input  logic                          cfg_we,
  input  logic [epr_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [epr_pkg::CfgDataW-1:0]  cfg_data
);
  import epr_pkg::*;

  // --- configuration registers ---
  mood_t             lid_shape;
  logic              blink_active;
  logic signed [3:0] pupil_offset_x;
  logic signed [3:0] pupil_offset_y;
  logic signed [6:0] hue_phase;
  logic [3:0]        pupil_radius;

  // --- control ---
  state_t      state, state_next;
  logic [31:0] noise_state;
  logic        out_valid;
  logic        out_free;
  logic        in_beat;

  // --- per-pixel payload ---
  logic              band_ok;      // column inside an eye band
  logic              eye_sel;      // 0 left, 1 right
  logic [6:0]        y_q;
  logic signed [6:0] dx;
  logic signed [7:0] dy;
  logic [10:0]       dx_sq;
  logic [12:0]       dy_sq;
  logic [10:0]       ix_sq;
  logic              eye_ok;       // in an eye band, inside ellipse and below lid
  logic              edge_ring;
  shade_t            shade_q;
  logic [7:0]        g_sc;
  logic [ColorW-1:0] out_color;

  // --- shared multiplier ---
  logic signed [MulOpW-1:0]   mul_a, mul_b;
  logic signed [MulProdW-1:0] prod;

  epr_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // saturating >>8 of a non-negative gain product
  function automatic logic [7:0] sat_gain(input logic signed [MulProdW-1:0] p);
    logic [MulProdW-9:0] v;
    v = p[MulProdW-1:8];
    return (v > (MulProdW-8)'(255)) ? 8'hFF : v[7:0];
  endfunction

  assign in_beat  = pixel_in.valid && pixel_in.ready;
  assign out_free = !out_valid || color_out.ready;

  assign pixel_in.ready        = (state == S_IDLE);
  assign color_out.valid       = out_valid;
  assign color_out.pixel_color = out_color;

  // --- column bands and centre offsets at accept ---
  logic              band_in, sel_in;
  logic signed [8:0] dx_full;
  logic signed [7:0] dy_in;

  always_comb begin
    band_in = 1'b0;
    sel_in  = 1'b0;
    priority if (pixel_in.pixel_x < 8'd6) begin
      band_in = 1'b0;
    end else if (pixel_in.pixel_x < 8'd75) begin
      band_in = 1'b1;
    end else if (pixel_in.pixel_x < 8'd86) begin
      band_in = 1'b0;
    end else if (pixel_in.pixel_x < 8'd155) begin
      band_in = 1'b1;
      sel_in  = 1'b1;
    end else begin
      band_in = 1'b0;
    end
    dx_full = $signed({1'b0, pixel_in.pixel_x})
            - (sel_in ? 9'(EyeCxRight) : 9'(EyeCxLeft));
    dy_in   = $signed({1'b0, pixel_in.pixel_y}) - 8'(EyeCy);
  end

  // --- iris-relative coordinates (offsets are to stay put during an item; not enforced here) ---
  logic signed [8:0] ix_full, iy_full;
  logic signed [7:0] ix, iy;

  assign ix_full = {{2{dx[6]}}, dx} - {{5{pupil_offset_x[3]}}, pupil_offset_x};
  assign iy_full = {dy[7], dy} - {{5{pupil_offset_y[3]}}, pupil_offset_y};
  assign ix      = ix_full[7:0];
  assign iy      = iy_full[7:0];

  // --- ellipse, eyelid and warm edge from the registered squares ---
  logic [24:0]       ell_x, ell_y, ell_lim;
  logic signed [7:0] inner;
  logic signed [9:0] inner3;
  logic [6:0]        inner_mag;
  logic [14:0]       div_prod;
  logic signed [7:0] lid_q, lid;
  logic              lid_cut;
  logic              eye_ok_next;

  always_comb begin
    ell_x   = blink_active ? 25'(dx_sq) * 25'd9 : 25'(dx_sq) << 10;
    ell_y   = 25'(dy_sq) * 25'(EyeRxSq);
    ell_lim = blink_active ? EllLimBlink : EllLimOpen;

    // (inner * 3) / 7 toward zero; |inner*3| <= 102, reciprocal 293/2048
    inner     = eye_sel ? -{dx[6], dx} : {dx[6], dx};
    inner3    = {{2{inner[7]}}, inner} * 10'sd3;
    inner_mag = inner3[9] ? 7'(-inner3) : 7'(inner3);
    div_prod  = 15'(inner_mag) * 15'd293;
    lid_q     = inner3[9] ? -{4'b0, div_prod[14:11]} : {4'b0, div_prod[14:11]};

    lid     = 8'sd0;
    lid_cut = 1'b0;
    unique case (lid_shape)
      MOOD_OPEN:  lid_cut = 1'b0;
      MOOD_ANGRY: begin
        lid     = 8'sd32 - lid_q;
        lid_cut = $signed({1'b0, y_q}) <= lid;
      end
      MOOD_FLAT: begin
        lid     = 8'sd26;
        lid_cut = $signed({1'b0, y_q}) <= lid;
      end
      MOOD_SAD: begin
        lid     = 8'sd18 + lid_q;
        lid_cut = $signed({1'b0, y_q}) <= lid;
      end
      default: lid_cut = 1'b0;
    endcase

    eye_ok_next = band_ok && !((ell_x + ell_y) > ell_lim)
                && !(lid_cut && !blink_active);
  end

  // --- noise step and iris shading ---
  logic [31:0] ns1, ns2, noise_nx;
  logic [13:0] id_sq;
  shade_t      sh;

  assign ns1      = noise_state ^ (noise_state << 13);
  assign ns2      = ns1 ^ (ns1 >> 17);
  assign noise_nx = ns2 ^ (ns2 << 5);
  assign id_sq    = {3'b0, ix_sq} + 14'(prod[13:0]);

  epr_shade u_shade (
    .eye_sel      (eye_sel),
    .ix           (ix),
    .iy           (iy),
    .id_sq        (id_sq),
    .noise        (noise_nx),
    .pupil_radius (pupil_radius),
    .sh           (sh)
  );

  // --- multiplier operand select ---
  logic signed [10:0] gain_g, gain_b;

  assign gain_g = 11'sd256 - {{4{hue_phase[6]}}, hue_phase};
  assign gain_b = 11'sd256 + {{4{hue_phase[6]}}, hue_phase};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_SQ_DX: begin
        mul_a = {{4{dx[6]}}, dx};
        mul_b = {{4{dx[6]}}, dx};
      end
      S_SQ_DY: begin
        mul_a = {{3{dy[7]}}, dy};
        mul_b = {{3{dy[7]}}, dy};
      end
      S_SQ_IX: begin
        mul_a = {{3{ix[7]}}, ix};
        mul_b = {{3{ix[7]}}, ix};
      end
      S_SQ_IY: begin
        mul_a = {{3{iy[7]}}, iy};
        mul_b = {{3{iy[7]}}, iy};
      end
      S_MUL_G: begin
        mul_a = $signed({3'b0, shade_q.g});
        mul_b = gain_g;
      end
      // blue operands held through the finish wait, so the product stays put
      S_MUL_B, S_FINISH: begin
        mul_a = $signed({3'b0, shade_q.b});
        mul_b = gain_b;
      end
      S_IDLE, S_SHADE: begin
        mul_a = '0;
        mul_b = '0;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // --- sequencer ---
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_beat) state_next = S_SQ_DX;
      S_SQ_DX:  state_next = S_SQ_DY;
      S_SQ_DY:  state_next = S_SQ_IX;
      S_SQ_IX:  state_next = S_SQ_IY;
      S_SQ_IY:  state_next = S_SHADE;
      S_SHADE:  state_next = S_MUL_G;
      S_MUL_G:  state_next = S_MUL_B;
      S_MUL_B:  state_next = S_FINISH;
      S_FINISH: if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // --- final colour ---
  logic [7:0]        b_sc;
  logic [ColorW-1:0] color_next;

  assign b_sc = sat_gain(prod);

  always_comb begin
    priority if (!eye_ok) begin
      color_next = ColBlack;
    end else if (!shade_q.iris) begin
      color_next = edge_ring ? ColWarm : ColWhite;
    end else if (shade_q.pupil) begin
      color_next = ColBlack;
    end else if (shade_q.glint_lo) begin
      color_next = ColFaint;
    end else if (shade_q.glint_hi) begin
      color_next = ColWhite;
    end else begin
      color_next = {shade_q.r[7:3], g_sc[7:2], b_sc[7:3]};
    end
  end

  // --- control registers ---
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      noise_state    <= NoiseSeed;
      lid_shape      <= MOOD_OPEN;
      blink_active   <= 1'b0;
      pupil_offset_x <= 4'sd0;
      pupil_offset_y <= 4'sd0;
      hue_phase      <= 7'sd0;
      pupil_radius   <= 4'd6;
    end else begin
      state <= state_next;

      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (color_out.ready) begin
        out_valid <= 1'b0;
      end

      // speckle word steps once per iris pixel inside the eye
      if (state == S_SHADE && eye_ok && sh.iris) begin
        noise_state <= noise_nx;
      end

      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_LID_SHAPE:    lid_shape      <= mood_t'(cfg_data[1:0]);
          REG_BLINK:        blink_active   <= cfg_data[0];
          REG_OFFSET_X:     pupil_offset_x <= cfg_data[3:0];
          REG_OFFSET_Y:     pupil_offset_y <= cfg_data[3:0];
          REG_HUE_PHASE:    hue_phase      <= cfg_data[6:0];
          REG_PUPIL_RADIUS: pupil_radius   <= cfg_data[3:0];
          default: ;
        endcase
      end
    end
  end

  // --- payload registers ---
  always_ff @(posedge clk) begin
    if (in_beat) begin
      band_ok <= band_in;
      eye_sel <= sel_in;
      y_q     <= pixel_in.pixel_y;
      dx      <= band_in ? dx_full[6:0] : 7'sd0;
      dy      <= dy_in;
    end
    if (state == S_SQ_DY) begin
      dx_sq <= prod[10:0];
    end
    if (state == S_SQ_IX) begin
      dy_sq <= prod[12:0];
    end
    if (state == S_SQ_IY) begin
      ix_sq     <= prod[10:0];
      eye_ok    <= eye_ok_next;
      edge_ring <= (14'(dx_sq) + 14'(dy_sq)) > EdgeLim;
    end
    if (state == S_SHADE) begin
      shade_q <= sh;
    end
    if (state == S_MUL_B) begin
      g_sc <= sat_gain(prod);
    end
    if (state == S_FINISH && out_free) begin
      out_color <= color_next;
    end
  end

`ifndef SYNTHESIS
  // an accepted pixel starts the multiply sequence on the next cycle
  a_start: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> state == S_SQ_DX)
    else $error("sequencer did not start after pixel beat");

  // a finished pixel waits while the result register is still occupied
  a_wait: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && out_valid && !color_out.ready) |=> state == S_FINISH)
    else $error("result overwritten while still pending");

  // speckle word moves only in the shading step
  a_noise: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && noise_state != $past(noise_state)) |-> $past(state) == S_SHADE)
    else $error("noise word stepped outside shading");

  // any pupil lies within the iris
  a_pupil: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL_G |-> (!shade_q.pupil || shade_q.iris))
    else $error("pupil flagged outside iris");
`endif

endmodule
